FILE: hdl/keyboard_rollover_report_table_macros.svh
// assertion macros for the keyboard rollover report table
`ifndef KEYBOARD_ROLLOVER_REPORT_TABLE_MACROS_SVH
`define KEYBOARD_ROLLOVER_REPORT_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define KRRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KRRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KRRT_ASSERT_IMP(lbl, ante, cons, msg)
`define KRRT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/krrt_pkg.sv
// types and constants shared by the keyboard rollover report table
package krrt_pkg;

    localparam int SLOT_FIELDS = 6;

    typedef enum logic [3:0] {
        OP_ENABLE    = 4'd0,
        OP_DISABLE   = 4'd1,
        OP_PRESS     = 4'd2,
        OP_RELEASE   = 4'd3,
        OP_CLEAR     = 4'd4,
        OP_SET_MODS  = 4'd5,
        OP_OR_MODS   = 4'd6,
        OP_CLR_MODS  = 4'd7,
        OP_QUERY     = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_READY   = 3'd1,
        ST_INVALID     = 3'd2,
        ST_FULL        = 3'd3,
        ST_NOT_FOUND   = 3'd4,
        ST_ALREADY_OFF = 3'd5
    } t_status;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] key_code;
        logic [7:0] modifier_bits;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [7:0] modifier_state;
        logic [7:0] slot_key_0;
        logic [7:0] slot_key_1;
        logic [7:0] slot_key_2;
        logic [7:0] slot_key_3;
        logic [7:0] slot_key_4;
        logic [7:0] slot_key_5;
        logic [2:0] pressed_count;
        logic       key_present;
    } t_rsp;

    typedef struct packed {
        logic       wipe;
        logic       press;
        logic       release_key;
        logic [7:0] code;
    } t_cell_ctl;

endpackage

FILE: hdl/keyboard_rollover_report_table.sv
// top level of the keyboard rollover report table
//
//  channel   direction  valid         stall         payload
//  request   in         i_in_valid    o_in_stall    i_in_data  (t_req)
//  result    out        o_out_valid   i_out_stall   o_out_data (t_rsp)
//
// the slot cells update and the result is registered in the same edge
// a new request is taken every cycle while the result register is free or being taken
// synchronous active-low reset clears the slots, the modifier byte and the enable flag
// a stalled result holds and stalls the request side in turn
`include "keyboard_rollover_report_table_macros.svh"

module keyboard_rollover_report_table
    import krrt_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    logic       r_enabled;
    logic       n_enabled;
    logic [7:0] r_mods;
    logic [7:0] n_mods;
    logic       r_out_valid;
    t_rsp       r_out;
    t_rsp       n_out;

    logic       w_acc;
    t_cell_ctl  w_ctl;
    t_status    w_status;
    logic       w_found;
    logic       w_full;
    logic       w_present;
    logic [2:0] w_count;
    logic [2:0] n_count;
    logic [KEY_SLOTS-1:0] w_nz;
    logic [KEY_SLOTS-1:0] w_nz_inc;
    logic [KEY_SLOTS-1:0] w_hit;
    logic [KEY_SLOTS-1:0] w_prev_nz;
    logic [KEY_SLOTS-1:0] w_hit_in;
    logic [7:0] w_key   [KEY_SLOTS];
    logic [7:0] w_next  [KEY_SLOTS];
    logic [7:0] w_upper [KEY_SLOTS];
    logic [7:0] w_slot  [SLOT_FIELDS];

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_acc       = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // slot chain
    for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign w_prev_nz[i] = 1'b1;
            assign w_hit_in[i]  = 1'b0;
        end else begin : g_link
            assign w_prev_nz[i] = w_nz[i-1];
            assign w_hit_in[i]  = w_hit[i-1];
        end
        if (i == KEY_SLOTS - 1) begin : g_last
            assign w_upper[i] = 8'd0;
        end else begin : g_mid
            assign w_upper[i] = w_key[i+1];
        end

        krrt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_prev_nz   (w_prev_nz[i]),
            .i_hit_in    (w_hit_in[i]),
            .i_upper_key (w_upper[i]),
            .o_key       (w_key[i]),
            .o_next_key  (w_next[i]),
            .o_nz        (w_nz[i]),
            .o_hit_out   (w_hit[i])
        );
    end

    for (genvar i = 0; i < SLOT_FIELDS; i++) begin : g_slot
        if (i < KEY_SLOTS) begin : g_used
            assign w_slot[i] = w_next[i];
        end else begin : g_unused
            assign w_slot[i] = 8'd0;
        end
    end

    assign w_found = w_hit[KEY_SLOTS-1];
    assign w_full  = w_nz[KEY_SLOTS-1];

    // operation decode
    always_comb begin
        w_ctl             = '0;
        w_ctl.code        = i_in_data.key_code;
        w_status          = ST_OK;
        n_enabled         = r_enabled;
        n_mods            = r_mods;
        case (t_op'(i_in_data.op))
            OP_ENABLE: begin
                if (!r_enabled) begin
                    w_ctl.wipe = w_acc;
                    n_enabled  = 1'b1;
                    n_mods     = 8'd0;
                end
            end
            OP_DISABLE: begin
                if (!r_enabled) begin
                    w_status = ST_ALREADY_OFF;
                end else begin
                    w_ctl.wipe = w_acc;
                    n_enabled  = 1'b0;
                    n_mods     = 8'd0;
                end
            end
            default: begin
                if (!r_enabled) begin
                    w_status = ST_NOT_READY;
                end else begin
                    case (t_op'(i_in_data.op))
                        OP_PRESS: begin
                            if (i_in_data.key_code == 8'd0) begin
                                w_status = ST_INVALID;
                            end else if (!w_found) begin
                                if (w_full) begin
                                    w_status = ST_FULL;
                                end else begin
                                    w_ctl.press = w_acc;
                                end
                            end
                        end
                        OP_RELEASE: begin
                            if (!w_found) begin
                                w_status = ST_NOT_FOUND;
                            end else begin
                                w_ctl.release_key = w_acc;
                            end
                        end
                        OP_CLEAR: begin
                            w_ctl.wipe = w_acc;
                            n_mods     = 8'd0;
                        end
                        OP_SET_MODS: n_mods = i_in_data.modifier_bits;
                        OP_OR_MODS:  n_mods = r_mods | i_in_data.modifier_bits;
                        OP_CLR_MODS: n_mods = r_mods & ~i_in_data.modifier_bits;
                        default: ;
                    endcase
                end
            end
        endcase
    end

    // report after the operation
    always_comb begin
        n_count   = 3'd0;
        w_present = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            n_count = n_count + 3'(w_next[i] != 8'd0);
            if (w_next[i] == i_in_data.key_code) begin
                w_present = 1'b1;
            end
        end
        w_present = w_present && n_enabled && (i_in_data.key_code != 8'd0);
    end

    always_comb begin
        n_out                = r_out;
        n_out.status         = w_status;
        n_out.modifier_state = n_mods;
        n_out.slot_key_0     = w_slot[0];
        n_out.slot_key_1     = w_slot[1];
        n_out.slot_key_2     = w_slot[2];
        n_out.slot_key_3     = w_slot[3];
        n_out.slot_key_4     = w_slot[4];
        n_out.slot_key_5     = w_slot[5];
        n_out.pressed_count  = n_count;
        n_out.key_present    = w_present;
    end

    always_comb begin
        w_count = 3'd0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            w_count = w_count + 3'(w_nz[i]);
        end
    end

    assign w_nz_inc = w_nz + KEY_SLOTS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_mods      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_enabled   <= n_enabled;
                r_mods      <= n_mods;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    `KRRT_ASSERT_IMP(a_off_empty, !r_enabled, (w_nz == '0) && (r_mods == 8'd0), "keys held while disabled")
    `KRRT_ASSERT_IMP(a_packed, 1'b1, (w_nz & w_nz_inc) == '0, "slots not packed from slot zero")
    `KRRT_ASSERT_NXT(a_release_count, w_ctl.release_key, w_count == $past(w_count) - 3'd1, "release did not drop one key")
    `KRRT_ASSERT_NXT(a_press_count, w_ctl.press, w_count == $past(w_count) + 3'd1, "press did not add one key")

endmodule

FILE: hdl/krrt_cell.sv
// one key slot of the report, linked to its neighbours
module krrt_cell
    import krrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  logic       i_prev_nz,
    input  logic       i_hit_in,
    input  logic [7:0] i_upper_key,
    output logic [7:0] o_key,
    output logic [7:0] o_next_key,
    output logic       o_nz,
    output logic       o_hit_out
);

    logic [7:0] r_key;
    logic [7:0] n_key;
    logic       w_match;

    assign w_match   = (r_key != 8'd0) && (r_key == i_ctl.code);
    assign o_hit_out = i_hit_in | w_match;
    assign o_nz      = (r_key != 8'd0);
    assign o_key     = r_key;
    assign o_next_key = n_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.wipe) begin
            n_key = 8'd0;
        end else if (i_ctl.release_key && o_hit_out) begin
            n_key = i_upper_key;
        end else if (i_ctl.press && !o_nz && i_prev_nz) begin
            n_key = i_ctl.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= 8'd0;
        end else begin
            r_key <= n_key;
        end
    end

endmodule
